// File: src/ncq_pkg.sv
`timescale 1ns / 1ps

package ncq_pkg;

  localparam int SEARCH_ENTRIES = 255;
  localparam int IDX_W          = 8;
  localparam int CH_W           = 16;
  localparam int ROM_W          = 24;
  localparam int DIST_W         = 10;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SEARCH_ENTRIES - 1);
  localparam logic [DIST_W-1:0] DIST_START = '1;

  localparam logic [1:0] CFG_KEY_RED     = 2'd0;
  localparam logic [1:0] CFG_KEY_GREEN   = 2'd1;
  localparam logic [1:0] CFG_KEY_BLUE    = 2'd2;
  localparam logic [1:0] CFG_KEY_ENABLED = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            enabled;
  } key_cfg_t;

endpackage

// File: src/ncq_rom.sv
`timescale 1ns / 1ps

module ncq_rom import ncq_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ROM_W-1:0] rd_data
);

  localparam logic [ROM_W-1:0] PALETTE [256] = '{
    24'h000000,
    24'h000000,24'h222222,24'h333333,24'h444444,24'h555555,24'h666666,24'h777777,24'h888888,
    24'h999999,24'hAAAAAA,24'hBBBBBB,24'hCCCCCC,24'hDDDDDD,24'hEEEEEE,24'hFFFFFF,
    24'h281400,24'h412300,24'h5F3200,24'h842100,24'hA05000,24'hC35F14,24'hE1731E,24'hFF8232,
    24'hFF9141,24'hFFA050,24'hFFAF5F,24'hFFBE73,24'hFFD282,24'hFFE191,24'hFFF0A0,
    24'h321E1E,24'h412220,24'h5F2830,24'h823040,24'hA03A4C,24'hBE4658,24'hE15464,24'hFF6670,
    24'hFF7F7B,24'hFF8E7F,24'hFF9F7F,24'hFFAF7F,24'hFFBF7F,24'hFFCF7F,24'hFFDF7F,
    24'h280D0D,24'h401515,24'h602020,24'h802A2A,24'hA03535,24'hC04040,24'hE04A4A,24'hFF5555,
    24'hFF6764,24'hFF6F64,24'hFF7584,24'hFF849D,24'hFF94B7,24'hFF9FD1,24'hFFAEEA,
    24'h901400,24'hA02000,24'hB03000,24'hC04000,24'hD05000,24'hE06000,24'hF07000,24'hFF8000,
    24'hFF9000,24'hFFA000,24'hFFB000,24'hFFC000,24'hFFD000,24'hFFE000,24'hFFF000,
    24'h280000,24'h400000,24'h600000,24'h800000,24'hA00000,24'hC00000,24'hE00000,24'hFF0000,
    24'hFF2828,24'hFF4040,24'hFF6060,24'hFF8080,24'hFFA0A0,24'hFFC0C0,24'hFFE0E0,
    24'h280028,24'h400040,24'h600060,24'h800080,24'hA000A0,24'hC000C0,24'hE000E0,24'hFF00FF,
    24'hFF28FF,24'hFF40FF,24'hFF60FF,24'hFF80FF,24'hFFA0FF,24'hFFC0FF,24'hFFE0FF,
    24'h281428,24'h402040,24'h603060,24'h804080,24'hA050A0,24'hC060C0,24'hE070E0,24'hFF7CFF,
    24'hFF8CFF,24'hFF9CFF,24'hFFACFF,24'hFFBCFF,24'hFFCCFF,24'hFFDCFF,24'hFFECFF,
    24'h280050,24'h350566,24'h420A7C,24'h4F0F92,24'h5C14A8,24'h6919BE,24'h761ED4,24'h8323EA,
    24'h9028FF,24'hA040FF,24'hB060FF,24'hC080FF,24'hD0A0FF,24'hE0C0FF,24'hF0E0FF,
    24'h000028,24'h000040,24'h000060,24'h000080,24'h0000A0,24'h0000C0,24'h0000E0,24'h0000FF,
    24'h0A28FF,24'h284AFF,24'h466AFF,24'h678AFF,24'h87AAFF,24'hA7CAFF,24'hC7EBFF,
    24'h0F1E1E,24'h142323,24'h193232,24'h1E4141,24'h285050,24'h325F5F,24'h377373,24'h418282,
    24'h469191,24'h50A0A0,24'h5AAFAF,24'h5FC3C3,24'h69D2D2,24'h73E1E1,24'h78F0F0,
    24'h002828,24'h004040,24'h006060,24'h008080,24'h00A0A0,24'h00C0C0,24'h00E0E0,24'h00FFFF,
    24'h28FFFF,24'h40FFFF,24'h60FFFF,24'h80FFFF,24'hA0FFFF,24'hC0FFFF,24'hE0FFFF,
    24'h002800,24'h004000,24'h006000,24'h008000,24'h00A000,24'h00C000,24'h00E000,24'h00FF00,
    24'h28FF28,24'h40FF40,24'h60FF60,24'h80FF80,24'hA0FFA0,24'hC0FFC0,24'hE0FFE0,
    24'h002110,24'h234123,24'h325F32,24'h418241,24'h50A050,24'h5FC35F,24'h73E173,24'h85FF7A,
    24'h91FF6E,24'hA0FF5F,24'hB4FF50,24'hC3FF41,24'hD2FF32,24'hE1FF23,24'hF0FF0F,
    24'h282800,24'h404000,24'h606000,24'h808000,24'hA0A000,24'hC0C000,24'hE0E000,24'hFFFF00,
    24'hFFFF28,24'hFFFF40,24'hFFFF60,24'hFFFF80,24'hFFFFA0,24'hFFFFC0,24'hFFFFE0,
    24'h442100,24'h00FF55,24'h0055FF,24'hFF5500,24'h55FF00,24'hFF0055,24'h5500FF,24'hCA8B25,
    24'hF078F0,24'hF0F078,24'hFF7F00,24'hDD6D01,24'h7AFF00,24'h111111,
    24'h000000,24'h0000AA,24'h00AA00,24'h00AAAA,24'hAA0000,24'hAA00AA,24'hAAAA00,24'hAAAAAA,
    24'h555555,24'h5555FF,24'h55FF55,24'h55FFFF,24'hFF5555,24'hFF55FF,24'hFFFF55,24'hFFFFFF
  };

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= PALETTE[rd_addr];
    end
  end

endmodule

// File: src/ncq_search.sv
`timescale 1ns / 1ps

module ncq_search import ncq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic [CH_W-1:0]  in_alpha,
  input  key_cfg_t         key_cfg,
  output logic             rom_rd_en,
  output logic [IDX_W-1:0] rom_rd_addr,
  input  logic [ROM_W-1:0] rom_rd_data,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_color_index
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [CH_W-1:0] ALPHA_FULL = '1;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              ev_valid_r, ev_valid_nxt;
  logic              ev_last_r, ev_last_nxt;
  logic [IDX_W-1:0]  ev_idx_r, ev_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [CH_W-1:0]   pix_r_r, pix_g_r, pix_b_r, pix_a_r;
  logic [CH_W-1:0]   pix_r_nxt, pix_g_nxt, pix_b_nxt, pix_a_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  match_r, match_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;

  logic [7:0]        ent_r, ent_g, ent_b;
  logic              key_hit, rom_hit, hit, take, is_key;
  logic [DIST_W-1:0] ent_dist;
  logic              found_upd;
  logic [IDX_W-1:0]  match_upd, best_upd, final_idx;
  logic [DIST_W-1:0] best_dist_upd;

  assign ent_r  = rom_rd_data[23:16];
  assign ent_g  = rom_rd_data[15:8];
  assign ent_b  = rom_rd_data[7:0];
  assign is_key = (ev_idx_r == '0);

  assign key_hit = key_cfg.enabled && (pix_a_r == ALPHA_FULL) &&
                   (pix_r_r == key_cfg.red) && (pix_g_r == key_cfg.green) &&
                   (pix_b_r == key_cfg.blue);
  assign rom_hit = (pix_a_r == ALPHA_FULL) && (pix_r_r == {ent_r, ent_r}) &&
                   (pix_g_r == {ent_g, ent_g}) && (pix_b_r == {ent_b, ent_b});
  assign hit     = ev_valid_r && (is_key ? key_hit : rom_hit);

  assign ent_dist = {2'b00, abs_diff(pix_r_r[15:8], ent_r)} +
                    {2'b00, abs_diff(pix_g_r[15:8], ent_g)} +
                    {2'b00, abs_diff(pix_b_r[15:8], ent_b)};
  assign take = ev_valid_r && !is_key && (ent_dist <= best_dist_r);

  assign best_upd      = take ? ev_idx_r : best_r;
  assign best_dist_upd = take ? ent_dist : best_dist_r;
  assign found_upd     = found_r || hit;
  assign match_upd     = found_r ? match_r : ev_idx_r;
  assign final_idx     = found_upd ? match_upd : best_upd;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    ev_valid_nxt  = (state_r == ST_SWEEP);
    ev_last_nxt   = (state_r == ST_SWEEP) && (addr_r == LAST_IDX);
    ev_idx_nxt    = addr_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    pix_r_nxt     = pix_r_r;
    pix_g_nxt     = pix_g_r;
    pix_b_nxt     = pix_b_r;
    pix_a_nxt     = pix_a_r;
    found_nxt     = found_upd;
    match_nxt     = match_upd;
    best_nxt      = best_upd;
    best_dist_nxt = best_dist_upd;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          pix_r_nxt     = in_red;
          pix_g_nxt     = in_green;
          pix_b_nxt     = in_blue;
          pix_a_nxt     = in_alpha;
          found_nxt     = 1'b0;
          match_nxt     = '0;
          best_nxt      = IDX_W'(1);
          best_dist_nxt = DIST_START;
          addr_nxt      = '0;
          if (in_alpha[CH_W-1]) begin
            state_nxt = ST_SWEEP;
          end else begin
            out_valid_nxt = 1'b1;
            out_idx_nxt   = '0;
          end
        end
      end
      ST_SWEEP: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (ev_last_r) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = final_idx;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ev_valid_r  <= 1'b0;
      ev_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_valid_r  <= ev_valid_nxt;
      ev_last_r   <= ev_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    ev_idx_r    <= ev_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    pix_r_r     <= pix_r_nxt;
    pix_g_r     <= pix_g_nxt;
    pix_b_r     <= pix_b_nxt;
    pix_a_r     <= pix_a_nxt;
    found_r     <= found_nxt;
    match_r     <= match_nxt;
    best_r      <= best_nxt;
    best_dist_r <= best_dist_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign rom_rd_en       = (state_r == ST_SWEEP);
  assign rom_rd_addr     = addr_r;
  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;

endmodule

// File: src/nearest_palette_color_quantizer.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// input     start / busy       in_red, in_green, in_blue, in_alpha (16 bits each)
// result    out_valid strobe   out_color_index (8 bits)
// config    cfg_we             cfg_index (2 bits), cfg_data (16 bits)
//
// An opaque pixel is compared with one ROM entry per cycle, read through the ROM's
// registered output; the result then passes through the result register.
// A transparent pixel gives its result in the cycle after accept.
// Busy holds off new pixels while the search runs; results cannot be stalled.
// Reset returns the key registers to their defaults and the sequencer to idle.
// The result strobe lasts one cycle; a new pixel may start in that same cycle.

module nearest_palette_color_quantizer import ncq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  input  logic [CH_W-1:0]  in_alpha,
  output logic             out_valid,
  output logic [IDX_W-1:0] out_color_index,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CH_W-1:0]  cfg_data
);

  key_cfg_t         key_cfg_r, key_cfg_nxt;
  logic             rom_rd_en;
  logic [IDX_W-1:0] rom_rd_addr;
  logic [ROM_W-1:0] rom_rd_data;

  always_comb begin
    key_cfg_nxt = key_cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_RED:     key_cfg_nxt.red     = cfg_data;
        CFG_KEY_GREEN:   key_cfg_nxt.green   = cfg_data;
        CFG_KEY_BLUE:    key_cfg_nxt.blue    = cfg_data;
        CFG_KEY_ENABLED: key_cfg_nxt.enabled = cfg_data[0];
        default: begin
          key_cfg_nxt = key_cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r.red     <= 16'hC0C0;
      key_cfg_r.green   <= 16'h2020;
      key_cfg_r.blue    <= 16'hFFFF;
      key_cfg_r.enabled <= 1'b0;
    end else begin
      key_cfg_r <= key_cfg_nxt;
    end
  end

  ncq_rom u_rom (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

  ncq_search u_search (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .key_cfg         (key_cfg_r),
    .rom_rd_en       (rom_rd_en),
    .rom_rd_addr     (rom_rd_addr),
    .rom_rd_data     (rom_rd_data),
    .out_valid       (out_valid),
    .out_color_index (out_color_index)
  );

endmodule

// File: src/ncq_checker.sv
`timescale 1ns / 1ps

module ncq_checker import ncq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic [CH_W-1:0]  in_alpha,
  input logic             out_valid,
  input logic [IDX_W-1:0] out_color_index
);

  a_transparent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_alpha[CH_W-1] |=> out_valid && (out_color_index == '0))
    else $error("transparent pixel did not give index zero");

  a_opaque_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_alpha[CH_W-1] |=> busy && !out_valid)
    else $error("opaque pixel did not start a search");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a search runs");

endmodule

bind nearest_palette_color_quantizer ncq_checker u_ncq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_alpha        (in_alpha),
  .out_valid       (out_valid),
  .out_color_index (out_color_index)
);
